>>> rtl/tcm_pkg.sv
// Shared types and codes for the typing case-mode controller.
// No dependencies; imported by tcm_step and typing_case_mode_controller_core.
package tcm_pkg;

   // Event kinds carried in req_type
   localparam logic [2:0] REQ_SEPARATOR     = 3'd0;
   localparam logic [2:0] REQ_BEFORE_LETTER = 3'd1;
   localparam logic [2:0] REQ_KEY_EMITTED   = 3'd2;
   localparam logic [2:0] REQ_SCAN          = 3'd3;
   localparam logic [2:0] REQ_MODE_ON       = 3'd4;
   localparam logic [2:0] REQ_TOGGLE        = 3'd5;
   localparam logic [2:0] REQ_OFF           = 3'd6;
   localparam logic [2:0] REQ_AUTOCAP       = 3'd7;

   // Pre-classified key codes
   localparam logic [3:0] CLS_OTHER      = 4'd0;
   localparam logic [3:0] CLS_SPACE      = 4'd1;
   localparam logic [3:0] CLS_HYPHEN     = 4'd2;
   localparam logic [3:0] CLS_UNDERSCORE = 4'd3;
   localparam logic [3:0] CLS_SLASH      = 4'd4;
   localparam logic [3:0] CLS_PAD_HYPHEN = 4'd5;
   localparam logic [3:0] CLS_PAD_SLASH  = 4'd6;
   localparam logic [3:0] CLS_DOT        = 4'd7;
   localparam logic [3:0] CLS_NONE       = 4'd8;
   localparam logic [3:0] CLS_TAB        = 4'd9;
   localparam logic [3:0] CLS_ALNUM      = 4'd10;

   // Case modes
   localparam logic [3:0] MODE_OFF    = 4'd0;
   localparam logic [3:0] MODE_CAMEL  = 4'd1;
   localparam logic [3:0] MODE_PASCAL = 4'd2;
   localparam logic [3:0] MODE_SNAKE  = 4'd3;
   localparam logic [3:0] MODE_CONST  = 4'd4;
   localparam logic [3:0] MODE_KEBAB  = 4'd5;
   localparam logic [3:0] MODE_DOT    = 4'd6;
   localparam logic [3:0] MODE_PATH   = 4'd7;
   localparam logic [3:0] MODE_PUNC   = 4'd8;

   // Separator actions
   localparam logic [2:0] SEP_PASS       = 3'd0;
   localparam logic [2:0] SEP_UNDERSCORE = 3'd1;
   localparam logic [2:0] SEP_MINUS      = 3'd2;
   localparam logic [2:0] SEP_SLASH      = 3'd3;
   localparam logic [2:0] SEP_DOT        = 3'd4;
   localparam logic [2:0] SEP_SWALLOW    = 3'd5;

   // Caps-lock commands
   localparam logic [1:0] CAPS_NONE = 2'd0;
   localparam logic [1:0] CAPS_ON   = 2'd1;
   localparam logic [1:0] CAPS_OFF  = 2'd2;

   localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd1000;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [3:0]  key_class;
      logic [3:0]  mode_sel;
      logic [15:0] now_ms;
   } tcm_req_type;

   typedef struct packed {
      logic [2:0] sep_action;
      logic       apply_shift;
      logic [1:0] caps_cmd;
      logic       is_active;
      logic [3:0] cur_mode;
   } tcm_rsp_type;

   typedef struct packed {
      logic        active_flag;
      logic [3:0]  mode_reg;
      logic        cap_next;
      logic [15:0] stamp_ms;
   } tcm_state_type;

endpackage

>>> rtl/typing_case_mode_controller_core.sv
// Top level of the typing case-mode controller: input register, state, result register.
// Depends on tcm_pkg and tcm_step.
//
// The controller takes one keystroke event per transaction and returns exactly one result
// per transaction. It sustains one transaction per clock cycle while rsp_stall is low. An
// accepted request goes into the input register, the single-pass event logic works on it,
// and the result register takes the outcome when free and shows it on rsp_valid. The
// controller state (active flag, mode, capitalise-next flag, idle stamp) is updated at the
// edge at which a transaction moves from the input register into the result register, so
// each event sees the effect of the one before it. req_stall rises only when both registers
// are full and rsp_stall is high. The user must write the idle timeout through csr_write_en/
// csr_write_data only while the block is idle; the block itself does not enforce this. The
// timeout resets to 1000 ms. Reset is synchronous and active high.
module typing_case_mode_controller_core
   import tcm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,

   input  logic          req_valid,
   output logic          req_stall,
   input  tcm_req_type   req_payload,

   output logic          rsp_valid,
   input  logic          rsp_stall,
   output tcm_rsp_type   rsp_payload,

   input  logic          csr_write_en,
   input  logic [15:0]   csr_write_data
);

   logic          in_valid_ff;
   tcm_req_type   in_item_ff;
   logic          out_valid_ff;
   tcm_rsp_type   out_item_ff;
   tcm_state_type state_ff;
   tcm_state_type state_in;
   tcm_rsp_type   result_in;
   logic [15:0]   timeout_ff;

   logic          advance;
   logic          accept;

   // Move the held transaction on whenever the result register is empty or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   tcm_step u_step (
      .req          (in_item_ff),
      .cur          (state_ff),
      .idle_timeout (timeout_ff),
      .nxt          (state_in),
      .rsp          (result_in)
   );

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         timeout_ff   <= IDLE_TIMEOUT_RESET;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end

         // Commit the event's effect together with its result
         if (advance) begin
            state_ff <= state_in;
         end

         if (csr_write_en) begin
            timeout_ff <= csr_write_data;
         end
      end
   end

   // Payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= result_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

>>> rtl/tcm_step.sv
// Combinational event logic: next controller state and result for one transaction.
// Depends on tcm_pkg.
module tcm_step
   import tcm_pkg::*;
(
   input  tcm_req_type   req,
   input  tcm_state_type cur,
   input  logic [15:0]   idle_timeout,
   output tcm_state_type nxt,
   output tcm_rsp_type   rsp
);

   logic [15:0] elapsed;
   logic        key_ok;
   logic [1:0]  off_caps;
   logic [1:0]  on_caps;
   logic        sel_ok;

   assign elapsed  = req.now_ms - cur.stamp_ms;
   assign off_caps = (cur.active_flag && cur.mode_reg == MODE_CONST) ? CAPS_OFF : CAPS_NONE;
   assign on_caps  = (req.mode_sel == MODE_CONST) ? CAPS_ON : CAPS_OFF;
   assign sel_ok   = (req.mode_sel <= MODE_PUNC);

   // Is the emitted key legal inside the current mode
   always_comb begin
      case (req.key_class) inside
         CLS_UNDERSCORE:             key_ok = (cur.mode_reg == MODE_SNAKE) ||
                                              (cur.mode_reg == MODE_CONST);
         CLS_HYPHEN, CLS_PAD_HYPHEN: key_ok = (cur.mode_reg == MODE_KEBAB);
         CLS_SLASH, CLS_PAD_SLASH,
         CLS_TAB:                    key_ok = (cur.mode_reg == MODE_PATH);
         CLS_DOT:                    key_ok = (cur.mode_reg == MODE_DOT);
         CLS_NONE:                   key_ok = cur.cap_next &&
                                              ((cur.mode_reg == MODE_CAMEL) ||
                                               (cur.mode_reg == MODE_PASCAL));
         CLS_ALNUM:                  key_ok = 1'b1;
         default:                    key_ok = 1'b0;
      endcase
   end

   always_comb begin
      nxt             = cur;
      rsp.sep_action  = SEP_PASS;
      rsp.apply_shift = 1'b0;
      rsp.caps_cmd    = CAPS_NONE;

      unique case (req.req_type)
         REQ_SEPARATOR: begin
            if (req.key_class >= CLS_SPACE && req.key_class <= CLS_SLASH) begin
               case (cur.mode_reg) inside
                  MODE_SNAKE, MODE_CONST:  rsp.sep_action = SEP_UNDERSCORE;
                  MODE_KEBAB:              rsp.sep_action = SEP_MINUS;
                  MODE_PATH:               rsp.sep_action = SEP_SLASH;
                  MODE_DOT:                rsp.sep_action = SEP_DOT;
                  MODE_CAMEL, MODE_PASCAL: begin
                     rsp.sep_action = SEP_SWALLOW;
                     nxt.cap_next   = 1'b1;
                  end
                  default:                 rsp.sep_action = SEP_PASS;
               endcase
            end
         end
         REQ_BEFORE_LETTER: begin
            if (cur.active_flag) begin
               rsp.apply_shift = cur.cap_next;
               nxt.cap_next    = 1'b0;
               if (cur.mode_reg == MODE_PUNC) begin
                  rsp.caps_cmd    = off_caps;
                  nxt.active_flag = 1'b0;
                  nxt.mode_reg    = MODE_OFF;
               end
            end
         end
         REQ_KEY_EMITTED: begin
            if (cur.active_flag && !key_ok) begin
               rsp.caps_cmd    = off_caps;
               nxt.active_flag = 1'b0;
               nxt.mode_reg    = MODE_OFF;
            end else begin
               nxt.stamp_ms = req.now_ms;
            end
         end
         REQ_SCAN: begin
            if (cur.active_flag && elapsed > idle_timeout) begin
               rsp.caps_cmd    = off_caps;
               nxt.active_flag = 1'b0;
               nxt.mode_reg    = MODE_OFF;
            end
         end
         REQ_MODE_ON, REQ_TOGGLE: begin
            if (sel_ok) begin
               if (req.req_type == REQ_TOGGLE && cur.active_flag &&
                   cur.mode_reg == req.mode_sel) begin
                  rsp.caps_cmd    = off_caps;
                  nxt.active_flag = 1'b0;
                  nxt.mode_reg    = MODE_OFF;
               end else begin
                  rsp.caps_cmd    = on_caps;
                  nxt.active_flag = 1'b1;
                  nxt.mode_reg    = req.mode_sel;
                  nxt.stamp_ms    = req.now_ms;
                  nxt.cap_next    = (req.mode_sel == MODE_PASCAL) ||
                                    (req.mode_sel == MODE_PUNC);
               end
            end
         end
         REQ_OFF: begin
            if (cur.active_flag) begin
               rsp.caps_cmd    = off_caps;
               nxt.active_flag = 1'b0;
               nxt.mode_reg    = MODE_OFF;
            end
         end
         REQ_AUTOCAP: begin
            // Any running mode is replaced outright by punctuation mode
            rsp.caps_cmd    = CAPS_OFF;
            nxt.active_flag = 1'b1;
            nxt.mode_reg    = MODE_PUNC;
            nxt.stamp_ms    = req.now_ms;
            nxt.cap_next    = 1'b1;
         end
         default: begin
            nxt = cur;
         end
      endcase

      rsp.is_active = nxt.active_flag;
      rsp.cur_mode  = nxt.mode_reg;
   end

endmodule

>>> tb/typing_case_mode_controller_core_tb.sv
// Self-checking testbench for typing_case_mode_controller_core: directed table, then random events.
// Depends on tcm_pkg and the controller RTL; predicts every result from its own copy of the state.
module typing_case_mode_controller_core_tb
   import tcm_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either channel
   localparam int PHASE_EVENTS   = 130;
   localparam int PLAN_LEN       = 28;

   // One row of the directed table: the event, whether its result is typed in, and that result
   typedef struct packed {
      tcm_req_type ev;
      logic        fixed;
      tcm_rsp_type want;
   } plan_row_type;

   localparam tcm_rsp_type ALL_IDLE  = '0;
   localparam tcm_rsp_type NOT_TYPED = '0;

   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // Nothing active: separators pass, key events only restamp, commands do nothing
      '{'{REQ_SEPARATOR, CLS_SPACE, MODE_OFF, 16'd0}, 1'b1, ALL_IDLE},
      '{'{REQ_BEFORE_LETTER, CLS_ALNUM, MODE_OFF, 16'd0}, 1'b1, ALL_IDLE},
      '{'{REQ_KEY_EMITTED, 4'd15, MODE_OFF, 16'hFFFF}, 1'b1, ALL_IDLE},
      '{'{REQ_SCAN, CLS_OTHER, MODE_OFF, 16'd0}, 1'b1, ALL_IDLE},
      '{'{REQ_OFF, CLS_OTHER, MODE_OFF, 16'd0}, 1'b1, ALL_IDLE},
      // Mode numbers above punc are ignored by mode on and toggle
      '{'{REQ_MODE_ON, CLS_OTHER, 4'd15, 16'd0}, 1'b1, ALL_IDLE},
      '{'{REQ_TOGGLE, CLS_OTHER, 4'd9, 16'd0}, 1'b1, ALL_IDLE},
      '{'{REQ_MODE_ON, CLS_OTHER, MODE_CONST, 16'd100}, 1'b1,
        '{SEP_PASS, 1'b0, CAPS_ON, 1'b1, MODE_CONST}},
      '{'{REQ_SEPARATOR, CLS_SLASH, MODE_OFF, 16'd0}, 1'b1,
        '{SEP_UNDERSCORE, 1'b0, CAPS_NONE, 1'b1, MODE_CONST}},
      '{'{REQ_KEY_EMITTED, CLS_UNDERSCORE, MODE_OFF, 16'd200}, 1'b0, NOT_TYPED},
      // Timeout boundary: elapsed equal to the limit holds, one more drops caps lock
      '{'{REQ_SCAN, CLS_OTHER, MODE_OFF, 16'd1200}, 1'b0, NOT_TYPED},
      '{'{REQ_SCAN, CLS_OTHER, MODE_OFF, 16'd1201}, 1'b1,
        '{SEP_PASS, 1'b0, CAPS_OFF, 1'b0, MODE_OFF}},
      '{'{REQ_TOGGLE, CLS_OTHER, MODE_PASCAL, 16'd65000}, 1'b0, NOT_TYPED},
      '{'{REQ_SEPARATOR, CLS_HYPHEN, MODE_OFF, 16'd0}, 1'b0, NOT_TYPED},
      '{'{REQ_KEY_EMITTED, CLS_NONE, MODE_OFF, 16'd65100}, 1'b0, NOT_TYPED},
      // Elapsed time wraps through zero
      '{'{REQ_SCAN, CLS_OTHER, MODE_OFF, 16'd500}, 1'b0, NOT_TYPED},
      '{'{REQ_BEFORE_LETTER, CLS_ALNUM, MODE_OFF, 16'd0}, 1'b0, NOT_TYPED},
      '{'{REQ_KEY_EMITTED, CLS_NONE, MODE_OFF, 16'd600}, 1'b0, NOT_TYPED},
      '{'{REQ_MODE_ON, CLS_OTHER, MODE_OFF, 16'd0}, 1'b0, NOT_TYPED},
      '{'{REQ_TOGGLE, CLS_OTHER, MODE_OFF, 16'd0}, 1'b0, NOT_TYPED},
      '{'{REQ_AUTOCAP, CLS_OTHER, MODE_OFF, 16'd0}, 1'b1,
        '{SEP_PASS, 1'b0, CAPS_OFF, 1'b1, MODE_PUNC}},
      '{'{REQ_BEFORE_LETTER, CLS_ALNUM, MODE_OFF, 16'd0}, 1'b0, NOT_TYPED},
      '{'{REQ_MODE_ON, CLS_OTHER, MODE_PATH, 16'd10}, 1'b0, NOT_TYPED},
      '{'{REQ_SEPARATOR, CLS_SPACE, MODE_OFF, 16'd0}, 1'b0, NOT_TYPED},
      '{'{REQ_TOGGLE, CLS_OTHER, MODE_CONST, 16'd20}, 1'b0, NOT_TYPED},
      '{'{REQ_OFF, CLS_OTHER, MODE_OFF, 16'd0}, 1'b1,
        '{SEP_PASS, 1'b0, CAPS_OFF, 1'b0, MODE_OFF}},
      '{'{REQ_MODE_ON, CLS_OTHER, MODE_DOT, 16'd30}, 1'b0, NOT_TYPED},
      '{'{REQ_SEPARATOR, CLS_UNDERSCORE, MODE_OFF, 16'd0}, 1'b0, NOT_TYPED}
   };

   logic          clock          = 1'b0;
   logic          reset          = 1'b1;
   logic          req_valid      = 1'b0;
   logic          req_stall;
   tcm_req_type   req_payload    = '0;
   logic          rsp_valid;
   logic          rsp_stall      = 1'b0;
   tcm_rsp_type   rsp_payload;
   logic          csr_write_en   = 1'b0;
   logic [15:0]   csr_write_data = '0;

   // Predicted controller state, advanced once per accepted request, and idle limit
   tcm_state_type shadow_state;
   logic [15:0]   idle_limit_ms;
   logic [15:0]   wall_ms = '0;

   tcm_rsp_type   pending_outcomes [$];
   int            failures   = 0;
   int            stall_left = 0;
   int            quiet_cycles = 0;
   bit            req_idling = 1'b1;
   bit            rsp_idling = 1'b1;

   typing_case_mode_controller_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------

   // Does this key keep the current mode alive? Classes above alnum count as other.
   function automatic logic key_keeps_mode(logic [3:0] kc);
      case (kc)
         CLS_UNDERSCORE:             return shadow_state.mode_reg inside {MODE_SNAKE, MODE_CONST};
         CLS_HYPHEN, CLS_PAD_HYPHEN: return shadow_state.mode_reg == MODE_KEBAB;
         CLS_SLASH, CLS_PAD_SLASH,
         CLS_TAB:                    return shadow_state.mode_reg == MODE_PATH;
         CLS_DOT:                    return shadow_state.mode_reg == MODE_DOT;
         CLS_NONE:                   return shadow_state.cap_next &&
                                        shadow_state.mode_reg inside {MODE_CAMEL, MODE_PASCAL};
         CLS_ALNUM:                  return 1'b1;
         default:                    return 1'b0;
      endcase
   endfunction

   // Drop the active mode; only const mode releases caps lock. Keep cap_next as it is.
   function automatic logic [1:0] drop_mode();
      logic [1:0] caps;
      caps = CAPS_NONE;
      if (shadow_state.active_flag) begin
         if (shadow_state.mode_reg == MODE_CONST)
            caps = CAPS_OFF;
         shadow_state.active_flag = 1'b0;
         shadow_state.mode_reg    = MODE_OFF;
      end
      return caps;
   endfunction

   function automatic logic [1:0] enter_mode(logic [3:0] m, logic [15:0] now);
      shadow_state.active_flag = 1'b1;
      shadow_state.mode_reg    = m;
      shadow_state.stamp_ms    = now;
      shadow_state.cap_next    = (m == MODE_PASCAL) || (m == MODE_PUNC);
      return (m == MODE_CONST) ? CAPS_ON : CAPS_OFF;
   endfunction

   // Apply one event to the predicted state and return the result it should produce
   function automatic tcm_rsp_type predict_event(tcm_req_type ev);
      tcm_rsp_type r;
      logic [15:0] elapsed;
      r = '0;
      case (ev.req_type)
         REQ_SEPARATOR: begin
            // Only space, minus, underscore and slash map; the mode decides, active or not
            if (ev.key_class >= CLS_SPACE && ev.key_class <= CLS_SLASH) begin
               case (shadow_state.mode_reg)
                  MODE_SNAKE, MODE_CONST: r.sep_action = SEP_UNDERSCORE;
                  MODE_KEBAB:             r.sep_action = SEP_MINUS;
                  MODE_PATH:              r.sep_action = SEP_SLASH;
                  MODE_DOT:               r.sep_action = SEP_DOT;
                  MODE_CAMEL, MODE_PASCAL: begin
                     shadow_state.cap_next = 1'b1;
                     r.sep_action          = SEP_SWALLOW;
                  end
                  default:                r.sep_action = SEP_PASS;
               endcase
            end
         end
         REQ_BEFORE_LETTER: begin
            if (shadow_state.active_flag) begin
               r.apply_shift         = shadow_state.cap_next;
               shadow_state.cap_next = 1'b0;
               if (shadow_state.mode_reg == MODE_PUNC)
                  r.caps_cmd = drop_mode();
            end
         end
         REQ_KEY_EMITTED: begin
            if (shadow_state.active_flag && !key_keeps_mode(ev.key_class))
               r.caps_cmd = drop_mode();
            else
               shadow_state.stamp_ms = ev.now_ms;
         end
         REQ_SCAN: begin
            elapsed = ev.now_ms - shadow_state.stamp_ms;
            if (shadow_state.active_flag && elapsed > idle_limit_ms)
               r.caps_cmd = drop_mode();
         end
         REQ_MODE_ON: begin
            if (ev.mode_sel <= MODE_PUNC)
               r.caps_cmd = enter_mode(ev.mode_sel, ev.now_ms);
         end
         REQ_TOGGLE: begin
            if (ev.mode_sel <= MODE_PUNC) begin
               if (shadow_state.active_flag && shadow_state.mode_reg == ev.mode_sel)
                  r.caps_cmd = drop_mode();
               else
                  r.caps_cmd = enter_mode(ev.mode_sel, ev.now_ms);
            end
         end
         REQ_OFF: r.caps_cmd = drop_mode();
         default: begin
            // Autocap: the caps command of the drop is overridden by the punc entry
            void'(drop_mode());
            r.caps_cmd = enter_mode(MODE_PUNC, ev.now_ms);
         end
      endcase
      r.is_active = shadow_state.active_flag;
      r.cur_mode  = shadow_state.mode_reg;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Random event generation: mostly keys that fit the current mode, so modes live long
   // enough to reach timeouts, shifts and separators; the rest is noise.
   // ---------------------------------------------------------------------------------------

   function automatic logic [3:0] fitting_key();
      logic coin;
      coin = 1'($urandom_range(0, 1));
      case (shadow_state.mode_reg)
         MODE_SNAKE, MODE_CONST:  return coin ? CLS_UNDERSCORE : CLS_ALNUM;
         MODE_KEBAB:              return coin ? CLS_HYPHEN : ($urandom_range(0, 1) ? CLS_PAD_HYPHEN
                                                                                : CLS_ALNUM);
         MODE_PATH:               return coin ? CLS_SLASH : ($urandom_range(0, 1) ? CLS_PAD_SLASH
                                                                               : CLS_TAB);
         MODE_DOT:                return coin ? CLS_DOT : CLS_ALNUM;
         MODE_CAMEL, MODE_PASCAL: return (shadow_state.cap_next && coin) ? CLS_NONE : CLS_ALNUM;
         default:                 return CLS_ALNUM;
      endcase
   endfunction

   function automatic tcm_req_type random_event();
      tcm_req_type ev;
      int pick;
      // Advance the millisecond clock, now and then by a long idle stretch
      wall_ms += ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 4000))
                                             : 16'($urandom_range(0, 40));
      ev.now_ms    = wall_ms;
      ev.key_class = ($urandom_range(0, 9) < 7) ? fitting_key() : 4'($urandom_range(0, 15));
      ev.mode_sel  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
      pick = $urandom_range(0, 99);
      if (!shadow_state.active_flag && pick < 50) begin
         if ($urandom_range(0, 4) == 0)
            ev.req_type = REQ_AUTOCAP;
         else
            ev.req_type = pick[0] ? REQ_MODE_ON : REQ_TOGGLE;
      end else if (pick < 18) begin
         ev.req_type = REQ_SEPARATOR;
         if ($urandom_range(0, 1))
            ev.key_class = 4'($urandom_range(1, 4));
      end else if (pick < 36) begin
         ev.req_type = REQ_BEFORE_LETTER;
      end else if (pick < 66) begin
         ev.req_type = REQ_KEY_EMITTED;
      end else if (pick < 80) begin
         ev.req_type = REQ_SCAN;
         // Aim at the timeout boundary: one below, at, and just past the limit
         if ($urandom_range(0, 1))
            ev.now_ms = shadow_state.stamp_ms + idle_limit_ms + 16'($urandom_range(0, 3))
                        - 16'd1;
      end else if (pick < 88) begin
         ev.req_type = REQ_MODE_ON;
      end else if (pick < 93) begin
         ev.req_type = REQ_TOGGLE;
         if ($urandom_range(0, 1))
            ev.mode_sel = shadow_state.mode_reg;
      end else if (pick < 97) begin
         ev.req_type = REQ_OFF;
      end else begin
         ev.req_type = REQ_AUTOCAP;
      end
      // Occasional raw noise over every bit of the request
      if ($urandom_range(0, 19) == 0)
         ev = tcm_req_type'($bits(tcm_req_type)'($urandom));
      return ev;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------------

   // Present one event, wait for the handshake, then record what it should return.
   // Valid stays high into the next transaction unless an idle burst or a drain lowers it.
   task automatic issue_event(input tcm_req_type ev, input logic fixed, input tcm_rsp_type want);
      tcm_rsp_type predicted;
      int gap;
      if (req_idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_event(ev);
      pending_outcomes.push_back(fixed ? want : predicted);
   endtask

   // Drop valid and hold until every outstanding result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_idle_limit(input logic [15:0] limit_ms);
      csr_write_en   <= 1'b1;
      csr_write_data <= limit_ms;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      idle_limit_ms  = limit_ms;
   endtask

   initial begin : stimulus
      int row;
      int ph;
      int n;
      shadow_state  = '0;
      idle_limit_ms = IDLE_TIMEOUT_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < PLAN_LEN; row++)
         issue_event(PLAN[row].ev, PLAN[row].fixed, PLAN[row].want);

      // Random phases, each under its own idle limit; the first keeps the reset value
      for (ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            drain_results();
            case (ph)
               1:       write_idle_limit(16'd0);
               2:       write_idle_limit(16'hFFFF);
               3:       write_idle_limit(16'($urandom_range(1, 2000)));
               default: write_idle_limit(16'd200);
            endcase
         end
         // Run the last phase flat out on both sides
         if (ph == 4) begin
            req_idling = 1'b0;
            rsp_idling = 1'b0;
         end
         for (n = 0; n < PHASE_EVENTS; n++) begin
            if (ph < 4 && n % 40 == 0) begin
               req_idling = $urandom_range(0, 2) != 0;
               rsp_idling = $urandom_range(0, 2) != 0;
            end
            issue_event(random_event(), 1'b0, NOT_TYPED);
         end
      end

      drain_results();
      repeat (6) @(posedge clock);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------------------------

   // Stall the result channel in random bursts while idling is enabled
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Compare each accepted result with the oldest outstanding expectation
   always @(posedge clock) begin : result_check
      tcm_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            failures++;
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_payload);
         end else begin
            want = pending_outcomes.pop_front();
            check_field("sep_action", 4'(want.sep_action), 4'(rsp_payload.sep_action));
            check_field("apply_shift", 4'(want.apply_shift), 4'(rsp_payload.apply_shift));
            check_field("caps_cmd", 4'(want.caps_cmd), 4'(rsp_payload.caps_cmd));
            check_field("is_active", 4'(want.is_active), 4'(rsp_payload.is_active));
            check_field("cur_mode", want.cur_mode, rsp_payload.cur_mode);
         end
      end
   end

   // Abort if neither channel completes a transaction for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

endmodule

>>> sim.f
rtl/tcm_pkg.sv
rtl/tcm_step.sv
rtl/typing_case_mode_controller_core.sv
tb/typing_case_mode_controller_core_tb.sv
